// ===== hdl/ocd_pkg.sv =====
// Shared types and constants for the object record checksum deframer.
package ocd_pkg;

	localparam int unsigned HeaderBytes = 3;

	typedef enum logic [1:0] {
		PH_TYPE   = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_LEN_HI = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_TYPE    = 3'd0,
		ROLE_LEN_LO  = 3'd1,
		ROLE_LEN_HI  = 3'd2,
		ROLE_PAYLOAD = 3'd3,
		ROLE_CHECK   = 3'd4
	} role_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [7:0] record_kind;
		role_t      byte_role;
		logic       record_end;
		logic       checksum_bad;
		logic       length_bad;
	} rec_t;

endpackage

// ===== hdl/ocd_byte_if.sv =====
// Input byte channel of the deframer.
interface ocd_byte_if
	import ocd_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/ocd_rec_if.sv =====
// Tagged byte result channel of the deframer.
interface ocd_rec_if
	import ocd_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [7:0] record_kind;
	logic [2:0] byte_role;
	logic       record_end;
	logic       checksum_bad;
	logic       length_bad;

	modport source (output valid, output byte_out, output record_kind, output byte_role,
		output record_end, output checksum_bad, output length_bad, input ready);
	modport sink (input valid, input byte_out, input record_kind, input byte_role,
		input record_end, input checksum_bad, input length_bad, output ready);
endinterface

// ===== hdl/ocd_parser.sv =====
// Record framing state machine: tags each accepted byte and tracks the checksum.
module ocd_parser
	import ocd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	output rec_t       res
);

	phase_t      phase_q, phase_d;
	logic [15:0] remain_q, remain_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  len_lo_q;

	logic [15:0] len_full;
	logic [15:0] remain_dec;
	logic [7:0]  sum_add;

	assign len_full   = {data_byte, len_lo_q};
	assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : 16'd0;
	assign sum_add    = sum_q + data_byte;

	// Next state.
	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		sum_d    = sum_add;
		kind_d   = kind_q;
		unique case (phase_q)
			PH_TYPE: begin
				kind_d  = data_byte;
				sum_d   = data_byte;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				remain_d = len_full;
				phase_d  = (len_full == 16'd0) ? PH_TYPE : PH_BODY;
			end
			PH_BODY: begin
				remain_d = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_d = PH_TYPE;
				end
			end
			default: phase_d = PH_TYPE;
		endcase
	end

	// Outputs for the byte being accepted.
	always_comb begin
		res.byte_out     = data_byte;
		res.record_kind  = kind_q;
		res.byte_role    = ROLE_TYPE;
		res.record_end   = 1'b0;
		res.checksum_bad = 1'b0;
		res.length_bad   = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				res.record_kind = data_byte;
			end
			PH_LEN_LO: begin
				res.byte_role = ROLE_LEN_LO;
			end
			PH_LEN_HI: begin
				res.byte_role  = ROLE_LEN_HI;
				res.record_end = (len_full == 16'd0);
				res.length_bad = (len_full == 16'd0);
			end
			PH_BODY: begin
				if (remain_dec == 16'd0) begin
					res.byte_role    = ROLE_CHECK;
					res.record_end   = 1'b1;
					res.checksum_bad = (sum_add != 8'd0);
				end else begin
					res.byte_role = ROLE_PAYLOAD;
				end
			end
			default: res.byte_role = ROLE_TYPE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			remain_q <= 16'd0;
			sum_q    <= 8'd0;
			kind_q   <= 8'd0;
			len_lo_q <= 8'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			sum_q    <= sum_d;
			kind_q   <= kind_d;
			if (phase_q == PH_LEN_LO) begin
				len_lo_q <= data_byte;
			end
		end
	end

endmodule

// ===== hdl/object_record_checksum_deframer.sv =====
// The framing update is a single add and decrement; each tagged result is registered.
// Throughput: one byte per cycle while the skid register is empty.
// A two-entry output buffer (result register plus skid register) keeps input
// ready high while one finished result waits for the sink.
// Reset: arst_n clears the framing state to expect a type byte and empties the buffer.
module object_record_checksum_deframer
	import ocd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ocd_byte_if.sink    byte_in,
	ocd_rec_if.source   rec_out
);

	rec_t res;
	rec_t out_s1, skid_q;
	logic out_vld_s1, skid_vld_q;
	logic in_fire, out_fire;

	assign byte_in.ready = !skid_vld_q;
	assign in_fire       = byte_in.valid && byte_in.ready;
	assign out_fire      = out_vld_s1 && rec_out.ready;

	ocd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.data_byte (byte_in.data_byte),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_s1 || out_fire) begin
				out_vld_s1 <= skid_vld_q || in_fire;
				skid_vld_q <= 1'b0;
			end else if (in_fire) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// The skid entry is older than a new transaction, so it moves first.
	always_ff @(posedge clk) begin
		if (!out_vld_s1 || out_fire) begin
			out_s1 <= skid_vld_q ? skid_q : res;
		end
		if (in_fire && !skid_vld_q) begin
			skid_q <= res;
		end
	end

	assign rec_out.valid        = out_vld_s1;
	assign rec_out.byte_out     = out_s1.byte_out;
	assign rec_out.record_kind  = out_s1.record_kind;
	assign rec_out.byte_role    = out_s1.byte_role;
	assign rec_out.record_end   = out_s1.record_end;
	assign rec_out.checksum_bad = out_s1.checksum_bad;
	assign rec_out.length_bad   = out_s1.length_bad;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_s1)
		else $error("skid entry held while output register empty");

	a_end_role: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_s1 && out_s1.record_end) |->
		(out_s1.byte_role == ROLE_CHECK || out_s1.byte_role == ROLE_LEN_HI))
		else $error("record end on a byte that cannot close a record");

	a_len_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_s1 && out_s1.length_bad) |->
		(out_s1.record_end && out_s1.byte_role == ROLE_LEN_HI))
		else $error("length error outside a closing length high byte");

	a_csum_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_s1 && out_s1.checksum_bad) |-> (out_s1.byte_role == ROLE_CHECK))
		else $error("checksum error on a non-checksum byte");
`endif

endmodule
